>>> rtl/dllm_pkg.sv
// Shared types and constants for the doubly linked list manager.
// Used by dllm_list and doubly_linked_list_manager_top; no dependencies.
`default_nettype none

package dllm_pkg;

   // Default pool size and value width
   localparam int DLLM_CAPACITY   = 64;
   localparam int DLLM_DATA_WIDTH = 32;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_BACK  = 2'd1,
      REQ_REMOVE     = 2'd2
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // List controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_LINK,
      S_FIX,
      S_WALK,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/dllm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dllm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/dllm_list.sv
// List controller: slot pool in value/next/prev RAMs plus a free-slot stack RAM,
// head/tail/count registers and the request state machine.
// Depends on dllm_pkg and dllm_ram.
`default_nettype none

module dllm_list #(
   parameter int CAPACITY   = dllm_pkg::DLLM_CAPACITY,
   parameter int DATA_WIDTH = dllm_pkg::DLLM_DATA_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request side
   input  wire logic                          start_valid,
   output logic                               start_ready,
   input  wire dllm_pkg::req_kind_type        start_kind,
   input  wire logic [DATA_WIDTH-1:0]         start_value,
   // result side
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output dllm_pkg::status_type               res_status,
   output logic [$clog2(CAPACITY+1)-1:0]      res_count
);

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // control registers
   dllm_pkg::state_type     state_ff, state_in;
   logic [SW-1:0]           head_ff, head_in;
   logic [SW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           sp_ff, sp_in;
   // per-item working registers
   dllm_pkg::req_kind_type  kind_ff, kind_in;
   logic [DATA_WIDTH-1:0]   value_ff, value_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [SW-1:0]           cur_ff, cur_in;
   logic [CW-1:0]           walk_ff, walk_in;
   dllm_pkg::status_type    status_ff, status_in;

   // RAM ports
   logic                    val_we, nxt_we, prv_we, stk_we, stk_re, rd_en;
   logic [SW-1:0]           val_wa, nxt_wa, prv_wa, stk_wa, stk_ra, rd_addr;
   logic [DATA_WIDTH-1:0]   val_wd, val_rd;
   logic [SW-1:0]           nxt_wd, prv_wd, stk_wd, nxt_rd, prv_rd, stk_rd;

   // helpers
   logic [CW-1:0]           sp_dec;
   logic [CW-1:0]           walk_nx;
   logic                    is_full, is_empty, hit, last, is_head, is_tail;

   assign sp_dec   = sp_ff - CW'(1);
   assign walk_nx  = walk_ff + CW'(1);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign hit      = (val_rd == value_ff);
   assign last     = (walk_nx == count_ff);
   assign is_head  = (cur_ff == head_ff);
   assign is_tail  = (cur_ff == tail_ff);

   // slot memories: value, forward link, backward link, free-slot stack
   dllm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(val_rd)
   );
   dllm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_nxt_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(nxt_rd)
   );
   dllm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prv_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(prv_rd)
   );
   dllm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stk_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dllm_pkg::S_IDLE: begin
            if (start_valid) begin
               unique case (start_kind) inside
                  dllm_pkg::REQ_PUSH_FRONT, dllm_pkg::REQ_PUSH_BACK: begin
                     if (is_full)             state_in = dllm_pkg::S_DONE;
                     else if (sp_ff != '0)    state_in = dllm_pkg::S_ALLOC;
                     else                     state_in = dllm_pkg::S_LINK;
                  end
                  dllm_pkg::REQ_REMOVE: begin
                     state_in = is_empty ? dllm_pkg::S_DONE : dllm_pkg::S_WALK;
                  end
                  default: state_in = dllm_pkg::S_DONE;
               endcase
            end
         end
         dllm_pkg::S_ALLOC: state_in = dllm_pkg::S_LINK;
         dllm_pkg::S_LINK: begin
            state_in = is_empty ? dllm_pkg::S_DONE : dllm_pkg::S_FIX;
         end
         dllm_pkg::S_FIX:  state_in = dllm_pkg::S_DONE;
         dllm_pkg::S_WALK: begin
            if (hit || last) state_in = dllm_pkg::S_DONE;
         end
         dllm_pkg::S_DONE: begin
            if (res_ready) state_in = dllm_pkg::S_IDLE;
         end
         default: state_in = dllm_pkg::S_IDLE;
      endcase
   end

   // datapath and memory commands
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      sp_in     = sp_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      slot_in   = slot_ff;
      cur_in    = cur_ff;
      walk_in   = walk_ff;
      status_in = status_ff;
      val_we = 1'b0; val_wa = slot_ff; val_wd = value_ff;
      nxt_we = 1'b0; nxt_wa = slot_ff; nxt_wd = slot_ff;
      prv_we = 1'b0; prv_wa = slot_ff; prv_wd = slot_ff;
      stk_we = 1'b0; stk_wa = sp_ff[SW-1:0]; stk_wd = cur_ff;
      stk_re = 1'b0; stk_ra = sp_dec[SW-1:0];
      rd_en  = 1'b0; rd_addr = head_ff;

      unique case (state_ff)
         dllm_pkg::S_IDLE: begin
            if (start_valid) begin
               kind_in   = start_kind;
               value_in  = start_value;
               status_in = dllm_pkg::ST_OK;
               unique case (start_kind) inside
                  dllm_pkg::REQ_PUSH_FRONT, dllm_pkg::REQ_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = dllm_pkg::ST_FULL;
                     end else if (sp_ff != '0) begin
                        // reuse a freed slot from the stack
                        stk_re = 1'b1;
                        sp_in  = sp_dec;
                     end else begin
                        // take the next never-used slot
                        slot_in = fill_ff[SW-1:0];
                        fill_in = fill_ff + CW'(1);
                     end
                  end
                  dllm_pkg::REQ_REMOVE: begin
                     if (is_empty) begin
                        status_in = dllm_pkg::ST_NOT_FOUND;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = head_ff;
                        cur_in  = head_ff;
                        walk_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         dllm_pkg::S_ALLOC: begin
            slot_in = stk_rd;
         end
         dllm_pkg::S_LINK: begin
            // fill the new slot
            val_we = 1'b1;
            nxt_we = 1'b1;
            prv_we = 1'b1;
            if (is_empty) begin
               head_in  = slot_ff;
               tail_in  = slot_ff;
               count_in = count_ff + CW'(1);
            end else if (kind_ff == dllm_pkg::REQ_PUSH_FRONT) begin
               nxt_wd = head_ff;
            end else begin
               prv_wd = tail_ff;
            end
         end
         dllm_pkg::S_FIX: begin
            // hook the old end entry to the new slot
            if (kind_ff == dllm_pkg::REQ_PUSH_FRONT) begin
               prv_we  = 1'b1;
               prv_wa  = head_ff;
               head_in = slot_ff;
            end else begin
               nxt_we  = 1'b1;
               nxt_wa  = tail_ff;
               tail_in = slot_ff;
            end
            count_in = count_ff + CW'(1);
         end
         dllm_pkg::S_WALK: begin
            if (hit) begin
               // unlink cur: neighbors point past it, slot goes to the free stack
               nxt_we = !is_head;
               nxt_wa = prv_rd;
               nxt_wd = nxt_rd;
               prv_we = !is_tail;
               prv_wa = nxt_rd;
               prv_wd = prv_rd;
               stk_we = 1'b1;
               sp_in  = sp_ff + CW'(1);
               if (is_head) head_in = nxt_rd;
               if (is_tail) tail_in = prv_rd;
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end else if (last) begin
               status_in = dllm_pkg::ST_NOT_FOUND;
            end else begin
               // follow the forward link straight from the read data
               rd_en   = 1'b1;
               rd_addr = nxt_rd;
               cur_in  = nxt_rd;
               walk_in = walk_nx;
            end
         end
         dllm_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dllm_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         sp_ff    <= sp_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      slot_ff   <= slot_in;
      cur_ff    <= cur_in;
      walk_ff   <= walk_in;
      status_ff <= status_in;
   end

   assign start_ready = (state_ff == dllm_pkg::S_IDLE);
   assign res_valid   = (state_ff == dllm_pkg::S_DONE);
   assign res_status  = status_ff;
   assign res_count   = count_ff;

endmodule

`default_nettype wire

>>> rtl/doubly_linked_list_manager_top.sv
// Top level of the doubly linked list manager: stream ports, result register
// and checks. Depends on dllm_pkg, dllm_list and dllm_ram.
//
// Usage:
//   Request items enter on req_* (tvalid/tready); req_tuser carries the request
//   kind (push front, push back, remove first match), req_tdata the value.
//   One result item per request leaves on rsp_*: status and the entry count
//   after the request.
//   One request is worked on at a time. A push steps through S_LINK and S_FIX
//   to S_DONE (S_LINK only into an empty list), with S_ALLOC first when it
//   reuses a freed slot (one read of the free-slot stack). A remove walks the
//   entries from the head in S_WALK until a match or the last entry; the walk
//   follows one forward link per cycle through the registered read port of the
//   link RAM. Full, empty and unknown requests go straight to S_DONE.
//   The next request is accepted the cycle after the previous result moves
//   into the output register, even while that result still waits on
//   rsp_tready; a stalled receiver holds the block after that.
//   Reset empties the list at once (head, tail, count, slot fill and free
//   stack pointers cleared); RAM contents are not cleared and need no pass.
`default_nettype none

module doubly_linked_list_manager_top #(
   parameter int CAPACITY   = dllm_pkg::DLLM_CAPACITY,
   parameter int DATA_WIDTH = dllm_pkg::DLLM_DATA_WIDTH
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request channel
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]           req_tdata,  // value
   input  wire logic [1:0]                                req_tuser,  // req_type
   // result channel
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic [(($clog2(CAPACITY+1)+2+7)/8)*8-1:0]      rsp_tdata   // status, count
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int RSP_TW = ((CW + 2 + 7) / 8) * 8;

   logic                         start_ready;
   logic                         res_valid, res_ready, load;
   dllm_pkg::status_type         res_status;
   logic [CW-1:0]                res_count;
   logic signed [DATA_WIDTH-1:0] req_value;

   logic                         rsp_valid_ff, rsp_valid_in;
   dllm_pkg::status_type         rsp_status_ff;
   logic [CW-1:0]                rsp_count_ff;

   assign req_value = signed'(req_tdata[DATA_WIDTH-1:0]);

   dllm_list #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_list (
      .clock      (clock),
      .reset      (reset),
      .start_valid(req_tvalid),
      .start_ready(start_ready),
      .start_kind (dllm_pkg::req_kind_type'(req_tuser)),
      .start_value(req_value),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_status (res_status),
      .res_count  (res_count)
   );

   assign req_tready = start_ready;

   // output register between the list controller and the receiver
   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'({rsp_count_ff, rsp_status_ff});

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= CW'(CAPACITY)))
      else $error("entry count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == dllm_pkg::ST_FULL) |->
         (rsp_count_ff == CW'(CAPACITY)))
      else $error("full status with room left in the pool");

endmodule

`default_nettype wire
